// File: rtl/bosd_pkg.sv
// ----------------------------------------------------------------------------
// bosd_pkg
// Shared widths, geometry constants, register codes and glyph/percent tables
// for the brightness OSD overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package bosd_pkg;

    localparam int COORD_BITS = 12;
    // signed width of panel-relative coordinates
    localparam int REL_W      = COORD_BITS + 4;

    localparam int PIX_W      = 32;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam int PANEL_W     = 180;
    localparam int PANEL_H     = 44;
    localparam int PANEL_R     = 22;
    localparam int PANEL_ALPHA = 102;
    localparam int PANEL_KEEP  = 255 - PANEL_ALPHA;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_PIX_W = 2 * GLYPH_COLS;
    localparam int GLYPH_PIX_H = 2 * GLYPH_ROWS;
    localparam int GLYPH_PITCH = 12;
    localparam int GLYPH_PCT   = 10;

    localparam int TEXT_MARGIN = 10;
    localparam int TEXT_TOP    = (PANEL_H - GLYPH_PIX_H) / 2;
    localparam int PCT_GAP     = 6;
    localparam int TEXT_TAIL   = 16;

    localparam int BAR_H       = 6;
    localparam int BAR_R       = 3;
    localparam int BAR_GAP     = 10;
    localparam int BAR_TOP     = (PANEL_H - BAR_H) / 2;
    localparam int BAR_X0_BASE = TEXT_MARGIN + TEXT_TAIL + BAR_GAP;
    localparam int BAR_RIGHT   = PANEL_W - 1 - TEXT_MARGIN;

    localparam int PCT_MAX     = 100;

    localparam logic [PIX_W-1:0] COLOR_TRACK = 32'hFF44_4444;
    localparam logic [PIX_W-1:0] COLOR_FILL  = 32'hFFFF_CC33;
    localparam logic [PIX_W-1:0] COLOR_TEXT  = 32'hFFFF_FFFF;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    localparam int RRECT_W_BITS = 8;
    localparam int RRECT_H_BITS = 6;
    localparam int RAD_BITS     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OSD_ENABLE     = 3'd0,
        REG_BRIGHTNESS_PCT = 3'd1,
        REG_FRAME_WIDTH    = 3'd2,
        REG_FRAME_HEIGHT   = 3'd3,
        REG_BOTTOM_GAP     = 3'd4
    } cfg_idx_t;

    // per-percentage decimal digits and fill width
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
        logic [6:0] fill;
    } pct_info_t;

    typedef pct_info_t [PCT_MAX:0] pct_tab_t;

    function automatic pct_tab_t build_pct_tab();
        pct_tab_t t;
        int       n;
        int       bw;
        for (int i = 0; i <= PCT_MAX; i++)
        begin
            n  = (i >= 100) ? 3 : ((i >= 10) ? 2 : 1);
            bw = BAR_RIGHT - (BAR_X0_BASE + GLYPH_PITCH * n) + 1;
            t[i].tens = 4'((i / 10) % 10);
            t[i].ones = 4'(i % 10);
            t[i].fill = 7'((bw * i) / 100);
        end
        return t;
    endfunction

    localparam pct_tab_t PCT_TAB = build_pct_tab();

    // 5x7 font rows, MSB is the leftmost column
    function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [3:0] g,
                                                       input logic [2:0] r);
        logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] rows;
        case (g)
            4'd0:    rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            4'd1:    rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            4'd2:    rows = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            4'd3:    rows = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            4'd4:    rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            4'd5:    rows = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            4'd6:    rows = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            4'd7:    rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            4'd8:    rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            4'd9:    rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            4'd10:   rows = {5'h0C, 5'h12, 5'h04, 5'h08, 5'h14, 5'h09, 5'h06};
            default: rows = '0;
        endcase
        return (r == 3'(GLYPH_ROWS)) ? '0 : rows[r];
    endfunction

endpackage

`default_nettype wire

// File: rtl/bosd_if.sv
// ----------------------------------------------------------------------------
// bosd interfaces
// Valid/ready channels for pixel requests, composited results and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bosd_pix_in_if import bosd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [PIX_W-1:0]      in_pixel;

    modport source (output valid, output pix_x, output pix_y, output in_pixel,
                    input ready);
    modport sink   (input valid, input pix_x, input pix_y, input in_pixel,
                    output ready);
endinterface

interface bosd_pix_out_if import bosd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             covered;

    modport source (output valid, output out_pixel, output covered, input ready);
    modport sink   (input valid, input out_pixel, input covered, output ready);
endinterface

interface bosd_cfg_if import bosd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/brightness_osd_pixel_overlay_unit.sv
// ----------------------------------------------------------------------------
// brightness_osd_pixel_overlay_unit
// Composites a brightness OSD panel, percentage text and bar onto ARGB8888
// pixels delivered in any scan order.
// ----------------------------------------------------------------------------
// One pixel request can be accepted every clock: an input register holds
// the request, one pass of logic works out panel, glyph and bar coverage,
// and the output register holds the composited pixel until the sink takes
// it. A stalled sink is absorbed by the two registers; once both hold a
// request, pix_in.ready follows pix_out.ready in the same cycle. The full
// rate of one pixel per clock holds as long as the sink keeps ready high.
// Register writes are always accepted (cfg.ready is tied high) and take
// effect on the next request; they are meant to be issued only while no
// pixel is in flight. A brightness_pct write whose low seven bits exceed
// 100 is stored as 100. Pixels outside the frame, or any pixel while
// osd_enable is 0, pass through with covered 0.
`default_nettype none

module brightness_osd_pixel_overlay_unit
    import bosd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    bosd_cfg_if.sink      cfg,
    bosd_pix_in_if.sink   pix_in,
    bosd_pix_out_if.source pix_out
);

    typedef logic signed [REL_W-1:0] rel_t;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // point inside a rounded rectangle, coordinates relative to its corner
    function automatic logic rrect_hit(input rel_t px, input rel_t py,
                                       input logic [RRECT_W_BITS-1:0] w,
                                       input logic [RRECT_H_BITS-1:0] h,
                                       input logic [RAD_BITS-1:0] rad);
        logic [RRECT_W_BITS-1:0] ux;
        logic [RRECT_H_BITS-1:0] uy;
        logic [RAD_BITS-1:0]     cx;
        logic [RAD_BITS-1:0]     cy;
        logic                    cx_in;
        logic                    cy_in;
        logic [10:0]             d2;
        logic [10:0]             r2;
        logic                    in_box;
        in_box = !(px < 0) && (px < $signed({{(REL_W-RRECT_W_BITS){1'b0}}, w}))
              && !(py < 0) && (py < $signed({{(REL_W-RRECT_H_BITS){1'b0}}, h}));
        ux = px[RRECT_W_BITS-1:0];
        uy = py[RRECT_H_BITS-1:0];
        cx = '0;
        cy = '0;
        cx_in = 1'b0;
        cy_in = 1'b0;
        if (ux < {3'b0, rad})
        begin
            cx_in = 1'b1;
            cx = RAD_BITS'({3'b0, rad} - 8'd1 - ux);
        end
        else if ({1'b0, ux} + {4'b0, rad} >= {1'b0, w})
        begin
            cx_in = 1'b1;
            cx = RAD_BITS'(ux + {3'b0, rad} - w);
        end
        if (uy < {1'b0, rad})
        begin
            cy_in = 1'b1;
            cy = RAD_BITS'({1'b0, rad} - 6'd1 - uy);
        end
        else if ({1'b0, uy} + {2'b0, rad} >= {1'b0, h})
        begin
            cy_in = 1'b1;
            cy = RAD_BITS'(uy + {1'b0, rad} - h);
        end
        d2 = {6'b0, cx} * {6'b0, cx} + {6'b0, cy} * {6'b0, cy};
        r2 = {6'b0, rad} * {6'b0, rad};
        return in_box && (!(cx_in && cy_in) || (d2 <= r2));
    endfunction

    // 2x-scaled glyph, coordinates relative to its top-left corner
    function automatic logic glyph_hit(input rel_t gu, input rel_t gv,
                                       input logic [3:0] g);
        logic [GLYPH_COLS-1:0] row;
        logic [2:0]            bit_sel;
        logic                  in_box;
        in_box = !(gu < 0) && (gu < REL_W'(GLYPH_PIX_W))
              && !(gv < 0) && (gv < REL_W'(GLYPH_PIX_H));
        row     = glyph_row(g, gv[3:1]);
        bit_sel = 3'(GLYPH_COLS - 1) - gu[3:1];
        return in_box && row[bit_sel];
    endfunction

    // c * (255 - alpha) / 255, exact for 16-bit products
    function automatic logic [7:0] blend_ch(input logic [7:0] c);
        logic [15:0] p;
        logic [16:0] q;
        p = {8'b0, c} * 16'(PANEL_KEEP);
        q = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return q[15:8];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                  osd_enable_reg;
    logic [PCT_W-1:0]      pct_reg;
    logic [COORD_BITS-1:0] frame_w_reg;
    logic [COORD_BITS-1:0] frame_h_reg;
    logic [COORD_BITS-1:0] gap_reg;
    logic [PCT_W-1:0]      pct_wr;

    assign cfg.ready = 1'b1;
    assign pct_wr = (cfg.data[PCT_W-1:0] > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                           : cfg.data[PCT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osd_enable_reg <= 1'b0;
            pct_reg        <= '0;
            frame_w_reg    <= COORD_BITS'(1280);
            frame_h_reg    <= COORD_BITS'(720);
            gap_reg        <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_OSD_ENABLE:     osd_enable_reg <= cfg.data[0];
                REG_BRIGHTNESS_PCT: pct_reg        <= pct_wr;
                REG_FRAME_WIDTH:    frame_w_reg    <= cfg.data;
                REG_FRAME_HEIGHT:   frame_h_reg    <= cfg.data;
                REG_BOTTOM_GAP:     gap_reg        <= cfg.data;
                default:            ;   // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: input register -> output register
    // ------------------------------------------------------------------
    logic                  s1_valid_reg, s1_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [PIX_W-1:0]      s1_pix_reg;
    logic [PIX_W-1:0]      out_pix_reg, out_pix_next;
    logic                  out_cov_reg, out_cov_next;
    logic                  s2_ready;
    logic                  s1_ready;

    assign s2_ready     = !out_valid_reg || pix_out.ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign pix_in.ready = s1_ready;

    always_comb
    begin
        s1_valid_next  = s1_ready ? pix_in.valid : s1_valid_reg;
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pix_in.valid)
        begin
            s1_x_reg   <= pix_in.pix_x;
            s1_y_reg   <= pix_in.pix_y;
            s1_pix_reg <= pix_in.in_pixel;
        end
        if (s2_ready && s1_valid_reg)
        begin
            out_pix_reg <= out_pix_next;
            out_cov_reg <= out_cov_next;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pix_reg;
    assign pix_out.covered   = out_cov_reg;

    // ------------------------------------------------------------------
    // geometry, all relative to the panel's top-left corner
    // ------------------------------------------------------------------
    rel_t      x_s, y_s, w_diff, w_round, panel_l, panel_t, u, v;
    rel_t      pct_glyph_x, bar_x0, bar_u, bar_v;
    logic [RRECT_W_BITS-1:0] bar_w;
    logic [RAD_BITS-1:0]     fill_rad;
    logic [1:0]              digit_cnt;
    logic [3:0]              d0, d1, d2;
    pct_info_t               info;
    logic                    active, in_panel, text_hit, track_hit, fill_hit;

    always_comb
    begin
        x_s = $signed({{(REL_W-COORD_BITS){1'b0}}, s1_x_reg});
        y_s = $signed({{(REL_W-COORD_BITS){1'b0}}, s1_y_reg});

        // left edge: (width - 180) / 2, rounded toward zero
        w_diff  = $signed({{(REL_W-COORD_BITS){1'b0}}, frame_w_reg}) - REL_W'(PANEL_W);
        w_round = w_diff + $signed({{(REL_W-1){1'b0}}, w_diff[REL_W-1]});
        panel_l = w_round >>> 1;
        panel_t = $signed({{(REL_W-COORD_BITS){1'b0}}, frame_h_reg})
                - $signed({{(REL_W-COORD_BITS){1'b0}}, gap_reg})
                - REL_W'(PANEL_H);
        u = x_s - panel_l;
        v = y_s - panel_t;

        active = osd_enable_reg && (s1_x_reg < frame_w_reg) && (s1_y_reg < frame_h_reg);

        info = PCT_TAB[pct_reg];

        // digit count sets the text and bar layout
        if (pct_reg >= PCT_W'(100))
        begin
            digit_cnt = 2'd3;
            d0 = 4'd1;
            d1 = 4'd0;
            d2 = 4'd0;
        end
        else if (pct_reg >= PCT_W'(10))
        begin
            digit_cnt = 2'd2;
            d0 = info.tens;
            d1 = info.ones;
            d2 = 4'd0;
        end
        else
        begin
            digit_cnt = 2'd1;
            d0 = info.ones;
            d1 = 4'd0;
            d2 = 4'd0;
        end

        case (digit_cnt)
            2'd3:
            begin
                pct_glyph_x = REL_W'(TEXT_MARGIN + GLYPH_PITCH * 3 + PCT_GAP);
                bar_x0      = REL_W'(BAR_X0_BASE + GLYPH_PITCH * 3);
                bar_w       = RRECT_W_BITS'(BAR_RIGHT - BAR_X0_BASE - GLYPH_PITCH * 3 + 1);
            end
            2'd2:
            begin
                pct_glyph_x = REL_W'(TEXT_MARGIN + GLYPH_PITCH * 2 + PCT_GAP);
                bar_x0      = REL_W'(BAR_X0_BASE + GLYPH_PITCH * 2);
                bar_w       = RRECT_W_BITS'(BAR_RIGHT - BAR_X0_BASE - GLYPH_PITCH * 2 + 1);
            end
            default:
            begin
                pct_glyph_x = REL_W'(TEXT_MARGIN + GLYPH_PITCH + PCT_GAP);
                bar_x0      = REL_W'(BAR_X0_BASE + GLYPH_PITCH);
                bar_w       = RRECT_W_BITS'(BAR_RIGHT - BAR_X0_BASE - GLYPH_PITCH + 1);
            end
        endcase

        in_panel = rrect_hit(u, v, RRECT_W_BITS'(PANEL_W), RRECT_H_BITS'(PANEL_H),
                             RAD_BITS'(PANEL_R));

        text_hit = glyph_hit(u - REL_W'(TEXT_MARGIN), v - REL_W'(TEXT_TOP), d0)
                || ((digit_cnt >= 2'd2)
                    && glyph_hit(u - REL_W'(TEXT_MARGIN + GLYPH_PITCH),
                                 v - REL_W'(TEXT_TOP), d1))
                || ((digit_cnt == 2'd3)
                    && glyph_hit(u - REL_W'(TEXT_MARGIN + 2 * GLYPH_PITCH),
                                 v - REL_W'(TEXT_TOP), d2))
                || glyph_hit(u - pct_glyph_x, v - REL_W'(TEXT_TOP), 4'(GLYPH_PCT));

        bar_u = u - bar_x0;
        bar_v = v - REL_W'(BAR_TOP);
        track_hit = rrect_hit(bar_u, bar_v, bar_w, RRECT_H_BITS'(BAR_H), RAD_BITS'(BAR_R));

        // narrow fill: corner radius limited to half the width
        fill_rad = (info.fill < 7'd6) ? RAD_BITS'(info.fill >> 1) : RAD_BITS'(BAR_R);
        fill_hit = (info.fill != 7'd0)
                && rrect_hit(bar_u, bar_v, {1'b0, info.fill}, RRECT_H_BITS'(BAR_H),
                             fill_rad);
    end

    // ------------------------------------------------------------------
    // layer composition: panel, text, track, fill (later wins)
    // ------------------------------------------------------------------
    always_comb
    begin
        out_pix_next = s1_pix_reg;
        out_cov_next = 1'b0;
        if (active)
        begin
            if (in_panel)
            begin
                out_pix_next = {ALPHA_OPAQUE, blend_ch(s1_pix_reg[23:16]),
                                blend_ch(s1_pix_reg[15:8]), blend_ch(s1_pix_reg[7:0])};
                out_cov_next = 1'b1;
            end
            if (text_hit)
            begin
                out_pix_next = COLOR_TEXT;
            end
            if (track_hit)
            begin
                out_pix_next = COLOR_TRACK;
            end
            if (fill_hit)
            begin
                out_pix_next = COLOR_FILL;
            end
        end
    end

endmodule

`default_nettype wire
